// ----- design/next_prime_search_defines.svh -----
// Assertion macros used by the next_prime_search RTL file.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef NEXT_PRIME_SEARCH_DEFINES_SVH
`define NEXT_PRIME_SEARCH_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define NPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define NPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/nps_pkg.sv -----
// Shared types and constants for the next_prime_search block.
// No dependencies.
`default_nettype none

package nps_pkg;

  // Width of the start value port.
  localparam int START_BITS = 32;

  // First odd trial divisor and its square.
  localparam int FIRST_DIV = 3;
  localparam int FIRST_SQ  = 9;
  // Step between odd candidates and between odd divisors.
  localparam int ODD_STEP  = 2;
  // Smallest candidate that enters the square check.
  localparam int MIN_TRIAL = 4;

  // Status from the serial remainder unit to the sequencer.
  typedef struct packed {
    logic done;   // one-cycle pulse: remainder ready
    logic zero;   // remainder is zero, valid with done
  } rem_stat_t;

endpackage

`default_nettype wire

// ----- design/nps_rem_serial.sv -----
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// Depends on nps_pkg (rem_stat_t).
`default_nettype none

module nps_rem_serial #(
  parameter int CAND_BITS = 33,
  parameter int DIV_BITS  = 19
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [CAND_BITS-1:0] dividend,
  input  wire logic [DIV_BITS-1:0]  divisor,
  output nps_pkg::rem_stat_t        stat
);

  localparam int CNT_BITS = $clog2(CAND_BITS + 1);

  logic [CAND_BITS-1:0] dvd_r, dvd_nxt;
  logic [DIV_BITS-1:0]  rem_r, rem_nxt;
  logic [CNT_BITS-1:0]  cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic                 zero_r, zero_nxt;
  logic [DIV_BITS:0]    trial;
  logic [DIV_BITS:0]    diff;
  logic                 fits;

  always_comb begin
    trial = {rem_r, dvd_r[CAND_BITS-1]};
    fits  = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_BITS'(CAND_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when the divisor fits
      dvd_nxt = {dvd_r[CAND_BITS-2:0], 1'b0};
      rem_nxt = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_BITS'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        zero_nxt = (fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0]) == '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r  <= dvd_nxt;
    rem_r  <= rem_nxt;
    zero_r <= zero_nxt;
  end

  assign stat.done = done_r;
  assign stat.zero = zero_r;

endmodule

`default_nettype wire

// ----- design/next_prime_search.sv -----
// next_prime_search: smallest odd prime at or above a start value.
//
// Input channel in_valid / in_stall carries in_start_value; only its low
// VALUE_BITS bits count. Result channel out_valid / out_stall carries
// out_prime_found, VALUE_BITS+1 bits wide. A transfer happens on a rising
// edge with valid high and stall low. One result per input, in order.
// The block works on one item at a time: in_stall is high from the
// accepting edge until the result is moved into the output register.
// A finished result waits there while the next item is already taken.
// When no trial division is needed (start values up to 7) the search ends
// without a remainder step; otherwise each trial divisor passes a
// square check, a remainder in the serial divider at one remainder bit
// per cycle, and a step on that remainder. The search time grows with the
// divisors tested over all candidates and is set by the bit-serial
// remainder unit.
// While out_stall is high and the result register is full, it holds and a
// finished search waits in its last state. Synchronous reset (rst_n low)
// drops any search in flight and empties the result register.
// Depends on nps_pkg, nps_rem_serial and next_prime_search_defines.svh.
`default_nettype none
`include "next_prime_search_defines.svh"

module next_prime_search #(
  parameter int VALUE_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [nps_pkg::START_BITS-1:0] in_start_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [VALUE_BITS:0]              out_prime_found
);

  localparam int CAND_BITS = VALUE_BITS + 1;
  localparam int DIV_BITS  = (CAND_BITS + 1) / 2 + 2;
  localparam int SQ_BITS   = CAND_BITS + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t                st_r, st_nxt;
  logic [CAND_BITS-1:0]  cand_r, cand_nxt;
  logic [DIV_BITS-1:0]   div_r, div_nxt;
  logic [SQ_BITS-1:0]    sq_r, sq_nxt;
  logic                  oval_r, oval_nxt;
  logic [CAND_BITS-1:0]  oprime_r, oprime_nxt;

  logic [VALUE_BITS-1:0] start_lo;
  logic [CAND_BITS-1:0]  cand_in;
  logic                  in_take;
  logic                  out_free;
  logic                  sq_over;
  logic                  rem_start;
  nps_pkg::rem_stat_t    rem_stat;

  assign in_stall = (st_r != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !oval_r || !out_stall;
  assign sq_over  = sq_r > {1'b0, cand_r};
  assign rem_start = (st_r == ST_CHECK) && !sq_over;

  // raise even starts to odd, then 1 to 3
  always_comb begin
    start_lo = VALUE_BITS'(in_start_value);
    cand_in  = {1'b0, start_lo} | CAND_BITS'(1);
    if (cand_in == CAND_BITS'(1)) begin
      cand_in = CAND_BITS'(nps_pkg::FIRST_DIV);
    end
  end

  always_comb begin
    st_nxt     = st_r;
    cand_nxt   = cand_r;
    div_nxt    = div_r;
    sq_nxt     = sq_r;
    oval_nxt   = oval_r && out_stall;
    oprime_nxt = oprime_r;
    unique case (st_r)
      ST_IDLE: begin
        if (in_take) begin
          cand_nxt = cand_in;
          div_nxt  = DIV_BITS'(nps_pkg::FIRST_DIV);
          sq_nxt   = SQ_BITS'(nps_pkg::FIRST_SQ);
          st_nxt   = (cand_in < CAND_BITS'(nps_pkg::MIN_TRIAL)) ? ST_OUT : ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sq_over) begin
          st_nxt = ST_OUT;
        end else begin
          st_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_stat.done) begin
          if (rem_stat.zero) begin
            // composite: move to the next odd candidate, restart divisors
            cand_nxt = cand_r + CAND_BITS'(nps_pkg::ODD_STEP);
            div_nxt  = DIV_BITS'(nps_pkg::FIRST_DIV);
            sq_nxt   = SQ_BITS'(nps_pkg::FIRST_SQ);
          end else begin
            // (d+2)^2 = d^2 + 4d + 4
            div_nxt = div_r + DIV_BITS'(nps_pkg::ODD_STEP);
            sq_nxt  = sq_r + SQ_BITS'({div_r, 2'b00}) + SQ_BITS'(nps_pkg::MIN_TRIAL);
          end
          st_nxt = ST_CHECK;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          oval_nxt   = 1'b1;
          oprime_nxt = cand_r;
          st_nxt     = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      oval_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      oval_r <= oval_nxt;
    end
    cand_r   <= cand_nxt;
    div_r    <= div_nxt;
    sq_r     <= sq_nxt;
    oprime_r <= oprime_nxt;
  end

  nps_rem_serial #(
    .CAND_BITS(CAND_BITS),
    .DIV_BITS (DIV_BITS)
  ) u_rem (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (rem_start),
    .dividend(cand_r),
    .divisor (div_r),
    .stat    (rem_stat)
  );

  assign out_valid       = oval_r;
  assign out_prime_found = oprime_r;

  `NPS_ASSERT_NOW(a_out_odd, oval_r, oprime_r[0] && (oprime_r >= CAND_BITS'(nps_pkg::FIRST_DIV)), "result is not an odd value of at least 3")
  `NPS_ASSERT_NOW(a_done_in_div, rem_stat.done, st_r == ST_DIV, "remainder finished outside a division")
  `NPS_ASSERT_NOW(a_div_odd, st_r == ST_DIV, div_r[0] && (div_r >= DIV_BITS'(nps_pkg::FIRST_DIV)), "trial divisor is not odd and at least 3")
  `NPS_ASSERT_NEXT(a_take_busy, in_take, st_r != ST_IDLE, "accepted item did not start a search")

endmodule

`default_nettype wire
